// File: design/nsf_pkg.sv
// Shared constants, the item type and the hex decode function of the NMEA sentence framer.
package nsf_pkg;

  localparam int unsigned MAX_LEN = 128;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned POS_W   = 7;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h3A;
  localparam logic [7:0] CH_HEX_LO = 8'h41;
  localparam logic [7:0] CH_HEX_HI = 8'h47;
  localparam logic [7:0] HEX_OFS   = 8'd55;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       is_dollar;
    logic       is_star;
    logic       is_cr;
    logic       is_lf;
    logic [3:0] hex;
  } item_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_DIG_LO && c < CH_DIG_HI) begin
        d = c - CH_DIG_LO;
      end else if (c >= CH_HEX_LO && c < CH_HEX_HI) begin
        d = c - HEX_OFS;
      end
      return d[3:0];
    end
  endfunction

endpackage

// File: design/nmea_sentence_framer_checksum.sv
// Top level of the NMEA sentence framer with checksum check.
// Path: an item is registered in the front stage, queued, then registered as a result in the back.
// Throughput: one item per cycle while the receiver does not stall; a two-entry queue parts front and back.
// Items that cause no result still pass through front, queue and back.
// Reset: rst_ni is asynchronous, active low, and clears framing state and
// all valid flags at once; no clearing pass follows.
module nmea_sentence_framer_checksum (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [6:0] position_o,
  output logic       end_of_sentence_o,
  output logic       checksum_ok_o,
  output logic [7:0] computed_sum_o,
  output logic [7:0] received_sum_o,
  output logic       overflow_o
);

  logic           f_valid, f_ready, b_valid, b_ready;
  nsf_pkg::item_t f_item, b_item;

  nsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  nsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  nsf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (b_valid),
    .item_ready_o      (b_ready),
    .item_i            (b_item),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .position_o        (position_o),
    .end_of_sentence_o (end_of_sentence_o),
    .checksum_ok_o     (checksum_ok_o),
    .computed_sum_o    (computed_sum_o),
    .received_sum_o    (received_sum_o),
    .overflow_o        (overflow_o)
  );

endmodule

// File: design/nsf_front.sv
// Front stage: accept input items, classify the byte and register the result.
module nsf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  logic [7:0]    data_byte_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output nsf_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  nsf_pkg::item_t item_q, item_d;
  logic           take;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    item_d.op        = op_i;
    item_d.data      = data_byte_i;
    item_d.is_dollar = (data_byte_i == nsf_pkg::CH_DOLLAR);
    item_d.is_star   = (data_byte_i == nsf_pkg::CH_STAR);
    item_d.is_cr     = (data_byte_i == nsf_pkg::CH_CR);
    item_d.is_lf     = (data_byte_i == nsf_pkg::CH_LF);
    item_d.hex       = nsf_pkg::hex_value(data_byte_i);
    valid_d          = take || (valid_q && !item_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: design/nsf_queue.sv
// Two-entry queue of classified items between front and back.
module nsf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  nsf_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output nsf_pkg::item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(nsf_pkg::QDEPTH);
  localparam int unsigned CNT_QW = $clog2(nsf_pkg::QDEPTH + 1);

  nsf_pkg::item_t mem_q [nsf_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_QW'(nsf_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = pop ? PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = CNT_QW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_QW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// File: design/nsf_back.sv
// Back stage: sentence framing, checksum and registered result output.
module nsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  nsf_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic [6:0]     position_o,
  output logic           end_of_sentence_o,
  output logic           checksum_ok_o,
  output logic [7:0]     computed_sum_o,
  output logic [7:0]     received_sum_o,
  output logic           overflow_o
);

  localparam int unsigned CW = nsf_pkg::CNT_W;

  logic          in_sent_q, in_sent_d;
  logic          held_q, held_d;
  logic          summing_q, summing_d;
  logic [7:0]    xor_q, xor_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          r0_cr_q, r0_cr_d;
  logic [3:0]    h0_q, h0_d, h1_q, h1_d, h2_q, h2_d;
  logic          ovf_q, ovf_d;

  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d, cs_q, cs_d, rs_q, rs_d;
  logic [6:0]    pos_q, pos_d;
  logic          eos_q, eos_d, ok_q, ok_d, of_q, of_d;

  logic          take, emit, fin, sum_n;
  logic [7:0]    rx;
  logic [CW-1:0] pos;
  logic [CW+6:0] pos_ext;

  assign item_ready_o = !ov_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    in_sent_d = in_sent_q;
    held_d    = held_q;
    summing_d = summing_q;
    xor_d     = xor_q;
    cnt_d     = cnt_q;
    r0_cr_d   = r0_cr_q;
    h0_d      = h0_q;
    h1_d      = h1_q;
    h2_d      = h2_q;
    ovf_d     = ovf_q;
    emit      = 1'b0;
    fin       = 1'b0;
    sum_n     = summing_q;
    rx        = {h2_q, h1_q};
    pos       = '0;
    ob_d      = item_i.data;
    eos_d     = 1'b0;
    ok_d      = 1'b0;
    rs_d      = 8'd0;
    cs_d      = 8'd0;
    of_d      = 1'b0;
    if (take) begin
      if (item_i.op == nsf_pkg::OP_RELEASE) begin
        held_d = 1'b0;
      end else if (held_q) begin
        held_d = held_q;
      end else if (!in_sent_q) begin
        if (item_i.is_dollar) begin
          in_sent_d = 1'b1;
          summing_d = 1'b0;
          xor_d     = 8'd0;
          ovf_d     = 1'b0;
          r0_cr_d   = 1'b0;
          h0_d      = item_i.hex;
          h1_d      = 4'd0;
          h2_d      = 4'd0;
          cnt_d     = CW'(1);
          emit      = 1'b1;
        end
      end else if (!item_i.is_dollar) begin
        if (cnt_q == CW'(1)) begin
          sum_n = 1'b1;
        end
        if (item_i.is_star) begin
          sum_n = 1'b0;
        end
        fin = item_i.is_lf && r0_cr_q;
        if (fin) begin
          in_sent_d = 1'b0;
          held_d    = 1'b1;
          summing_d = 1'b0;
        end else begin
          summing_d = sum_n;
          if (sum_n) begin
            xor_d = xor_q ^ item_i.data;
          end
        end
        if (cnt_q < CW'(nsf_pkg::MAX_LEN)) begin
          pos   = cnt_q;
          cnt_d = CW'(cnt_q + 1'b1);
          emit  = 1'b1;
        end else begin
          ovf_d = 1'b1;
          pos   = CW'(nsf_pkg::MAX_LEN - 1);
          emit  = fin;
        end
        r0_cr_d = item_i.is_cr;
        h0_d    = item_i.hex;
        h1_d    = h0_q;
        h2_d    = h1_q;
        eos_d   = fin;
        ok_d    = fin && (rx == xor_q);
        rs_d    = fin ? rx : 8'd0;
        cs_d    = xor_d;
        of_d    = ovf_d;
      end
    end
    pos_ext = {7'd0, pos};
    pos_d   = pos_ext[6:0];
    ov_d    = take ? emit : (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      held_q    <= 1'b0;
      summing_q <= 1'b0;
      xor_q     <= 8'd0;
      cnt_q     <= '0;
      r0_cr_q   <= 1'b0;
      h0_q      <= 4'd0;
      h1_q      <= 4'd0;
      h2_q      <= 4'd0;
      ovf_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d;
      held_q    <= held_d;
      summing_q <= summing_d;
      xor_q     <= xor_d;
      cnt_q     <= cnt_d;
      r0_cr_q   <= r0_cr_d;
      h0_q      <= h0_d;
      h1_q      <= h1_d;
      h2_q      <= h2_d;
      ovf_q     <= ovf_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      ob_q  <= ob_d;
      pos_q <= pos_d;
      eos_q <= eos_d;
      ok_q  <= ok_d;
      cs_q  <= cs_d;
      rs_q  <= rs_d;
      of_q  <= of_d;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_byte_o        = ob_q;
  assign position_o        = pos_q;
  assign end_of_sentence_o = eos_q;
  assign checksum_ok_o     = ok_q;
  assign computed_sum_o    = cs_q;
  assign received_sum_o    = rs_q;
  assign overflow_o        = of_q;

  a_held_not_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> !in_sent_q)
    else $error("held complete while framing");

  a_count_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sent_q |-> (cnt_q != '0))
    else $error("framing with zero byte count");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_sent_q && ovf_q) |-> (cnt_q == CW'(nsf_pkg::MAX_LEN)))
    else $error("overflow before buffer full");

  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ok_q) |-> (eos_q && (rs_q == cs_q)))
    else $error("checksum verdict inconsistent");

endmodule

// File: verif/nmea_sentence_framer_checksum_sb.sv
`timescale 1ns / 1ps
// Framer watcher: mirrors the sentence framing, predicts each result and compares it.
module nmea_sentence_framer_checksum_sb
  import nsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic [6:0] position_i,
  input  logic       end_of_sentence_i,
  input  logic       checksum_ok_i,
  input  logic [7:0] computed_sum_i,
  input  logic [7:0] received_sum_i,
  input  logic       overflow_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o,
  output int         ends_o,
  output int         good_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic [6:0] pos;
    logic       eos;
    logic       ok;
    logic [7:0] csum;
    logic [7:0] rsum;
    logic       ovf;
  } sentence_res_t;

  sentence_res_t due_results[$];
  sentence_res_t got;
  sentence_res_t want;
  sentence_res_t fresh;

  logic       in_frame;
  logic       held;
  logic       summing;
  logic [7:0] xor_acc;
  logic [7:0] stored;
  logic [7:0] hist [3];
  logic       overflowed;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c[3:0];
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  function automatic bit frame_byte(input logic op, input logic [7:0] b,
                                    output sentence_res_t r);
    logic       eos;
    logic [7:0] rx;
    logic [6:0] pos;
    bit         emit;
    eos = 1'b0;
    rx  = 8'd0;
    r   = '0;
    if (op == OP_RELEASE) begin
      held = 1'b0;
      return 1'b0;
    end
    if (held) begin
      return 1'b0;
    end
    if (!in_frame) begin
      if (b != CH_DOLLAR) begin
        return 1'b0;
      end
      in_frame   = 1'b1;
      summing    = 1'b0;
      xor_acc    = 8'd0;
      overflowed = 1'b0;
      hist[0]    = b;
      hist[1]    = 8'd0;
      hist[2]    = 8'd0;
      stored     = 8'd1;
      r.ch       = b;
      return 1'b1;
    end
    if (b == CH_DOLLAR) begin
      return 1'b0;
    end
    if (stored == 8'd1) begin
      summing = 1'b1;
    end
    if (b == CH_STAR) begin
      summing = 1'b0;
    end
    if (b == CH_LF && hist[0] == CH_CR) begin
      eos      = 1'b1;
      rx       = {digit_of(hist[2]), digit_of(hist[1])};
      in_frame = 1'b0;
      held     = 1'b1;
      summing  = 1'b0;
    end else if (summing) begin
      xor_acc = xor_acc ^ b;
    end
    if (stored < MAX_LEN) begin
      pos    = stored[6:0];
      stored = stored + 8'd1;
      emit   = 1'b1;
    end else begin
      overflowed = 1'b1;
      pos        = 7'(MAX_LEN - 1);
      emit       = eos;
    end
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = b;
    if (!emit) begin
      return 1'b0;
    end
    r.ch   = b;
    r.pos  = pos;
    r.eos  = eos;
    r.ok   = eos && (rx == xor_acc);
    r.csum = xor_acc;
    r.rsum = rx;
    r.ovf  = overflowed;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] g, input logic [7:0] w);
    if (g !== w) begin
      report($sformatf("%s: got %02h, want %02h (result %0d)", name, g, w, results_o));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame     = 1'b0;
      held         = 1'b0;
      summing      = 1'b0;
      xor_acc      = 8'd0;
      stored       = 8'd0;
      hist[0]      = 8'd0;
      hist[1]      = 8'd0;
      hist[2]      = 8'd0;
      overflowed   = 1'b0;
      due_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
      results_o    = 0;
      ends_o       = 0;
      good_o       = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_byte_i, position_i, end_of_sentence_i, checksum_ok_i,
                computed_sum_i, received_sum_i, overflow_i};
        if (due_results.size() == 0) begin
          report($sformatf("result with nothing due: byte %02h pos %0d", out_byte_i,
                           position_i));
        end else begin
          want = due_results.pop_front();
          check_field("out_byte", got.ch, want.ch);
          check_field("position", 8'(got.pos), 8'(want.pos));
          check_field("end_of_sentence", 8'(got.eos), 8'(want.eos));
          check_field("checksum_ok", 8'(got.ok), 8'(want.ok));
          check_field("computed_sum", got.csum, want.csum);
          check_field("received_sum", got.rsum, want.rsum);
          check_field("overflow", 8'(got.ovf), 8'(want.ovf));
          if (want.eos) begin
            ends_o++;
            if (want.ok) begin
              good_o++;
            end
          end
        end
        results_o++;
      end
      if (in_valid_i && in_ready_i) begin
        if (frame_byte(op_i, data_byte_i, fresh)) begin
          due_results.push_back(fresh);
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

// File: verif/nmea_sentence_framer_checksum_tb.sv
`timescale 1ns / 1ps
// Top of the framer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module nmea_sentence_framer_checksum_tb;
  import nsf_pkg::*;

  localparam int LIMIT  = 800000;
  localparam int TARGET = 1950;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       op_i        = OP_BYTE;
  logic [7:0] data_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [6:0] position_o;
  logic       end_of_sentence_o;
  logic       checksum_ok_o;
  logic [7:0] computed_sum_o;
  logic [7:0] received_sum_o;
  logic       overflow_o;

  int fails;
  int pending;
  int results;
  int ends;
  int good;

  int cycles     = 0;
  int sent_items = 0;
  int sentences  = 0;
  int stall_left = 0;
  int hold_seq   = 0;
  int hold_seen  = 0;
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;

  nmea_sentence_framer_checksum dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .position_o        (position_o),
    .end_of_sentence_o (end_of_sentence_o),
    .checksum_ok_o     (checksum_ok_o),
    .computed_sum_o    (computed_sum_o),
    .received_sum_o    (received_sum_o),
    .overflow_o        (overflow_o)
  );

  nmea_sentence_framer_checksum_sb u_sb (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .op_i              (op_i),
    .data_byte_i       (data_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_i        (out_byte_o),
    .position_i        (position_o),
    .end_of_sentence_i (end_of_sentence_o),
    .checksum_ok_i     (checksum_ok_o),
    .computed_sum_i    (computed_sum_o),
    .received_sum_i    (received_sum_o),
    .overflow_i        (overflow_o),
    .fail_count_o      (fails),
    .pending_o         (pending),
    .results_o         (results),
    .ends_o            (ends),
    .good_o            (good)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("nmea_sentence_framer_checksum: mismatch");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(25, 70);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen  = hold_seq;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_quiet) begin
        stall_left = idle_len();
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 85) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_DOLLAR || c == CH_STAR) begin
        c = 8'h47;
      end
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // sum_mode: 0 correct, 1 lower case, 2 random bytes, 3 no digits
  task automatic send_sentence(input int body_len, input int sum_mode, input bit with_star);
    logic [7:0] acc;
    logic [7:0] c;
    bit         open;
    acc  = 8'd0;
    open = 1'b1;
    push_item(OP_BYTE, CH_DOLLAR);
    for (int i = 0; i < body_len; i++) begin
      c = body_char();
      if (c == CH_STAR) begin
        open = 1'b0;
      end else if (open) begin
        acc = acc ^ c;
      end
      push_item(OP_BYTE, c);
    end
    if (with_star) begin
      push_item(OP_BYTE, CH_STAR);
    end
    case (sum_mode)
      0, 1: begin
        push_item(OP_BYTE, hex_char(acc[7:4], sum_mode == 1));
        push_item(OP_BYTE, hex_char(acc[3:0], sum_mode == 1));
      end
      2: begin
        push_item(OP_BYTE, 8'($urandom_range(0, 255)));
        push_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
    push_item(OP_BYTE, CH_CR);
    push_item(OP_BYTE, CH_LF);
    repeat ($urandom_range(0, 2)) push_item(OP_BYTE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) != 0) begin
      push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    end
    sentences++;
  endtask

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end
    if (r < 80) begin
      return 1;
    end
    if (r < 92) begin
      return 2;
    end
    return 3;
  endfunction

  initial begin
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle garbage, stray release, well-formed sentence with repeated '$'
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_RELEASE, 8'h00);
    push_item(OP_BYTE, CH_DOLLAR);
    push_item(OP_BYTE, CH_DOLLAR);
    push_item(OP_BYTE, 8'h41);
    push_item(OP_BYTE, 8'h47);
    push_item(OP_BYTE, CH_STAR);
    push_item(OP_BYTE, 8'h30);
    push_item(OP_BYTE, 8'h36);
    push_item(OP_BYTE, CH_CR);
    push_item(OP_BYTE, CH_LF);
    push_item(OP_BYTE, 8'h58);
    push_item(OP_RELEASE, 8'hFF);
    // shortest sentence: digits missing
    push_item(OP_BYTE, CH_DOLLAR);
    push_item(OP_BYTE, CH_CR);
    push_item(OP_BYTE, CH_LF);
    push_item(OP_RELEASE, 8'h00);
    // non-hex digits decode as zero
    push_item(OP_BYTE, CH_DOLLAR);
    push_item(OP_BYTE, CH_STAR);
    push_item(OP_BYTE, 8'h40);
    push_item(OP_BYTE, 8'h66);
    push_item(OP_BYTE, CH_CR);
    push_item(OP_BYTE, CH_LF);
    push_item(OP_RELEASE, 8'h00);

    // long receiver hold-off while bytes keep coming
    tx_quiet = 1'b1;
    hold_seq++;
    repeat (3) send_sentence(10, 0, 1'b1);
    tx_quiet = 1'b0;

    while (sent_items < TARGET) begin
      r        = $urandom_range(0, 99);
      tx_quiet = ($urandom_range(0, 9) == 0);
      rx_quiet = ($urandom_range(0, 9) == 0);
      if (r < 10) begin
        repeat ($urandom_range(1, 6)) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end else if (r < 12) begin
        send_sentence($urandom_range(130, 200), pick_mode(), 1'b1);
      end else if (r < 15) begin
        send_sentence($urandom_range(119, 126), pick_mode(), 1'b1);
      end else if (r < 20) begin
        send_sentence($urandom_range(0, 2), pick_mode(), 1'($urandom_range(0, 1)));
      end else begin
        send_sentence($urandom_range(0, 20), pick_mode(), $urandom_range(0, 9) != 0);
      end
    end
    in_valid_i <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d items in %0d sentences; %0d results checked, %0d sentence ends,",
             sent_items, sentences, results, ends);
    $display("%0d of them with a matching checksum, in %0d cycles.", good, cycles);
    if (fails == 0) begin
      $display("nmea_sentence_framer_checksum: match");
    end else begin
      $display("nmea_sentence_framer_checksum: mismatch");
    end
    $finish;
  end

endmodule
